// ===== src/ddo_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ddo_pkg - shared types and constants for the differential drive odometry
// Item types, register map, fixed-point constants, CORDIC angle table and
// the sequencer state encodings.
// ============================================================================
package ddo_pkg;

    // Default number of CORDIC rotations (legal range 8 to 30)
    localparam int CORDIC_STEPS_DEF = 18;

    // Register file
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_LEFT_DPC  = 2'd0;
    localparam logic [1:0] REG_RIGHT_DPC = 2'd1;
    localparam logic [1:0] REG_INV_TRACK = 2'd2;
    localparam logic [31:0] LEFT_DPC_RST  = 32'd10541439;
    localparam logic [31:0] RIGHT_DPC_RST = 32'd10541439;
    localparam logic [31:0] INV_TRACK_RST = 32'd20971520;

    // Heading arithmetic, Q3.16
    localparam logic signed [20:0] TWO_PI_Q16 = 21'sd411775;
    localparam logic [18:0]        DTHETA_MAX = 19'd411774;

    // CORDIC datapath, Q30 in a 35-bit word
    localparam int CW = 35;
    localparam logic signed [CW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [CW-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_Q30    = 35'sd652032874;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
    } cnt_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [19:0] heading_rad;
    } pose_item_t;

    typedef struct packed {
        logic [31:0] left_dpc;
        logic [31:0] right_dpc;
        logic [31:0] inv_track;
    } cfg_t;

    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] cos_v;
        logic signed [CW-1:0] sin_v;
    } cordic_sts_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_DIFF,
        ST_SUM,
        ST_ABS,
        ST_TH_HI,
        ST_TH_LO,
        ST_DTH,
        ST_HEAD,
        ST_C_START,
        ST_C_WAIT,
        ST_X_HI,
        ST_X_LO,
        ST_X_RES,
        ST_X_ADD,
        ST_Y_HI,
        ST_Y_LO,
        ST_Y_RES,
        ST_Y_ADD,
        ST_DONE
    } core_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_FOLD,
        CS_ITER,
        CS_OUT
    } cordic_state_t;

    // atan(2^-i) in Q30
    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CW-1:0] v;
        unique case (idx)
            5'd0:    v = 35'h3243F6A8;
            5'd1:    v = 35'h1DAC6705;
            5'd2:    v = 35'h0FADBAFC;
            5'd3:    v = 35'h07F56EA6;
            5'd4:    v = 35'h03FEAB76;
            5'd5:    v = 35'h01FFD55B;
            5'd6:    v = 35'h00FFFAAA;
            5'd7:    v = 35'h007FFF55;
            5'd8:    v = 35'h003FFFEA;
            5'd9:    v = 35'h001FFFFD;
            5'd10:   v = 35'h000FFFFF;
            5'd11:   v = 35'h0007FFFF;
            5'd12:   v = 35'h0003FFFF;
            5'd13:   v = 35'h0001FFFF;
            5'd14:   v = 35'h0000FFFF;
            5'd15:   v = 35'h00007FFF;
            5'd16:   v = 35'h00003FFF;
            5'd17:   v = 35'h00001FFF;
            5'd18:   v = 35'h00000FFF;
            5'd19:   v = 35'h000007FF;
            5'd20:   v = 35'h000003FF;
            5'd21:   v = 35'h000001FF;
            5'd22:   v = 35'h000000FF;
            5'd23:   v = 35'h0000007F;
            5'd24:   v = 35'h0000003F;
            5'd25:   v = 35'h0000001F;
            5'd26:   v = 35'h0000000F;
            5'd27:   v = 35'h00000008;
            5'd28:   v = 35'h00000004;
            5'd29:   v = 35'h00000002;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/ddo_mul.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ddo_mul - shared signed multiplier
// One 33x33 signed multiply per cycle with a registered product.
// ============================================================================
module ddo_mul (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] prod
);

    logic signed [65:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== src/ddo_cordic.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ddo_cordic - iterative CORDIC rotation
// Folds a Q3.16 heading into +-pi/2, then runs one rotation per cycle and
// returns cos and sin in Q30, sign-corrected for the fold.
// ============================================================================
module ddo_cordic #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [19:0]  heading,
    output ddo_pkg::cordic_sts_t sts
);

    localparam int CW = ddo_pkg::CW;
    localparam int IW = $clog2(CORDIC_STEPS);
    localparam logic [IW-1:0] LAST_ITER = IW'(CORDIC_STEPS - 1);

    ddo_pkg::cordic_state_t state_reg, state_next;

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [CW-1:0] cos_reg, sin_reg;
    logic [IW-1:0]        iter_reg;
    logic                 flip_reg;
    logic                 done_reg;

    logic signed [CW-1:0] a_w, a_fold_w, xs_w, ys_w, atan_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ddo_pkg::CS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ddo_pkg::CS_OUT);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ddo_pkg::CS_IDLE:
            begin
                if (start)
                begin
                    state_next = ddo_pkg::CS_FOLD;
                end
            end
            ddo_pkg::CS_FOLD: state_next = ddo_pkg::CS_ITER;
            ddo_pkg::CS_ITER:
            begin
                if (iter_reg == LAST_ITER)
                begin
                    state_next = ddo_pkg::CS_OUT;
                end
            end
            ddo_pkg::CS_OUT:  state_next = ddo_pkg::CS_IDLE;
            default:          state_next = ddo_pkg::CS_IDLE;
        endcase
    end

    // heading * 2^14 brings Q16 to Q30; first fold into +-pi
    always_comb
    begin
        a_w = {{(CW - 20){heading[19]}}, heading} <<< 14;
        if (a_w > ddo_pkg::PI_Q30)
        begin
            a_fold_w = a_w - ddo_pkg::TWO_PI_Q30;
        end
        else if (a_w < -ddo_pkg::PI_Q30)
        begin
            a_fold_w = a_w + ddo_pkg::TWO_PI_Q30;
        end
        else
        begin
            a_fold_w = a_w;
        end
    end

    assign xs_w   = x_reg >>> iter_reg;
    assign ys_w   = y_reg >>> iter_reg;
    assign atan_w = ddo_pkg::atan_q30(5'(iter_reg));

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ddo_pkg::CS_IDLE:
            begin
                if (start)
                begin
                    z_reg <= a_fold_w;
                end
            end
            ddo_pkg::CS_FOLD:
            begin
                // second fold into +-pi/2, result negated afterwards
                if (z_reg > ddo_pkg::HALF_PI_Q30)
                begin
                    z_reg    <= z_reg - ddo_pkg::PI_Q30;
                    flip_reg <= 1'b1;
                end
                else if (z_reg < -ddo_pkg::HALF_PI_Q30)
                begin
                    z_reg    <= z_reg + ddo_pkg::PI_Q30;
                    flip_reg <= 1'b1;
                end
                else
                begin
                    flip_reg <= 1'b0;
                end
                x_reg    <= ddo_pkg::GAIN_Q30;
                y_reg    <= '0;
                iter_reg <= '0;
            end
            ddo_pkg::CS_ITER:
            begin
                if (!z_reg[CW-1])
                begin
                    x_reg <= x_reg - ys_w;
                    y_reg <= y_reg + xs_w;
                    z_reg <= z_reg - atan_w;
                end
                else
                begin
                    x_reg <= x_reg + ys_w;
                    y_reg <= y_reg - xs_w;
                    z_reg <= z_reg + atan_w;
                end
                iter_reg <= iter_reg + 1'b1;
            end
            ddo_pkg::CS_OUT:
            begin
                cos_reg <= flip_reg ? -x_reg : x_reg;
                sin_reg <= flip_reg ? -y_reg : y_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign sts.done  = done_reg;
    assign sts.cos_v = cos_reg;
    assign sts.sin_v = sin_reg;

endmodule

// ===== src/ddo_apb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ddo_apb - configuration register file
// Three 32-bit registers at byte offsets 0, 4 and 8 (paddr[1:0] ignored);
// offsets 12 to 15 read 0 and ignore writes.
// ============================================================================
module ddo_apb (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ddo_pkg::ADDR_W-1:0]  paddr,
    input  logic [ddo_pkg::DATA_W-1:0]  pwdata,
    output logic [ddo_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ddo_pkg::cfg_t               cfg
);

    ddo_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_dpc  <= ddo_pkg::LEFT_DPC_RST;
            cfg_reg.right_dpc <= ddo_pkg::RIGHT_DPC_RST;
            cfg_reg.inv_track <= ddo_pkg::INV_TRACK_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                ddo_pkg::REG_LEFT_DPC:  cfg_reg.left_dpc  <= pwdata;
                ddo_pkg::REG_RIGHT_DPC: cfg_reg.right_dpc <= pwdata;
                ddo_pkg::REG_INV_TRACK: cfg_reg.inv_track <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ddo_pkg::REG_LEFT_DPC:  prdata = cfg_reg.left_dpc;
            ddo_pkg::REG_RIGHT_DPC: prdata = cfg_reg.right_dpc;
            ddo_pkg::REG_INV_TRACK: prdata = cfg_reg.inv_track;
            default:                prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

// ===== src/ddo_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ddo_core - odometry sequencer and datapath
// Steps one count item through the shared multiplier and the CORDIC unit
// and keeps the pose state and the output register.
// ============================================================================
module ddo_core #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ddo_pkg::cfg_t       cfg,
    input  logic                cnt_valid,
    output logic                cnt_stall,
    input  ddo_pkg::cnt_item_t  cnt_item,
    output logic                pose_valid,
    input  logic                pose_stall,
    output ddo_pkg::pose_item_t pose_item
);

    localparam int CW = ddo_pkg::CW;

    ddo_pkg::core_state_t state_reg, state_next;

    // pose state
    logic [31:0]        last_left_reg, last_right_reg;
    logic signed [31:0] pose_x_reg, pose_y_reg;
    logic signed [19:0] heading_reg;

    // working registers
    logic signed [31:0] dl_reg, dr_reg;
    logic signed [55:0] tl_reg, tr_reg;
    logic signed [55:0] center_reg;
    logic signed [56:0] diff_reg;
    logic [55:0]        cmag_reg;
    logic               cneg_reg;
    logic [56:0]        m_reg;
    logic               dneg_reg;
    logic [53:0]        hi_reg;
    logic signed [19:0] dth_reg;
    logic [31:0]        cosmag_reg, sinmag_reg;
    logic               cosneg_reg, sinneg_reg;
    logic [57:0]        acc_reg;
    logic [58:0]        r_reg;

    logic                pose_valid_reg, pose_valid_next;
    ddo_pkg::pose_item_t pose_item_reg;
    logic                load_out;

    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  prod;
    logic                cordic_start;
    ddo_pkg::cordic_sts_t cordic_sts;

    // combinational helpers
    logic signed [56:0] sum_w;
    logic               big_w, sat_w;
    logic [44:0]        th_sum_w;
    logic [20:0]        q_w;
    logic [18:0]        qc_w;
    logic signed [20:0] h_w, h_wrap_w;
    logic signed [CW-1:0] cos_abs_w, sin_abs_w;

    ddo_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    ddo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .heading (heading_reg),
        .sts     (cordic_sts)
    );

    // pose += (neg ? -mag : mag), clamped to 32-bit signed
    function automatic logic signed [31:0] sat_acc(
        input logic signed [31:0] base,
        input logic [58:0]        mag,
        input logic               neg
    );
        logic signed [60:0] b;
        logic signed [60:0] m;
        logic signed [60:0] s;
        b = {{29{base[31]}}, base};
        m = {2'b00, mag};
        s = neg ? (b - m) : (b + m);
        if (s > 61'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (s < -61'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ddo_pkg::ST_IDLE;
            pose_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pose_valid_reg <= pose_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        mul_a        = '0;
        mul_b        = '0;
        cordic_start = 1'b0;
        load_out     = 1'b0;
        unique case (state_reg)
            ddo_pkg::ST_IDLE:
            begin
                if (cnt_valid)
                begin
                    state_next = ddo_pkg::ST_MUL_L;
                end
            end
            ddo_pkg::ST_MUL_L:
            begin
                mul_a      = {dl_reg[31], dl_reg};
                mul_b      = {1'b0, cfg.left_dpc};
                state_next = ddo_pkg::ST_MUL_R;
            end
            ddo_pkg::ST_MUL_R:
            begin
                mul_a      = {dr_reg[31], dr_reg};
                mul_b      = {1'b0, cfg.right_dpc};
                state_next = ddo_pkg::ST_DIFF;
            end
            ddo_pkg::ST_DIFF:  state_next = ddo_pkg::ST_SUM;
            ddo_pkg::ST_SUM:   state_next = ddo_pkg::ST_ABS;
            ddo_pkg::ST_ABS:   state_next = ddo_pkg::ST_TH_HI;
            ddo_pkg::ST_TH_HI:
            begin
                mul_a      = {11'b0, m_reg[43:22]};
                mul_b      = {1'b0, cfg.inv_track};
                state_next = ddo_pkg::ST_TH_LO;
            end
            ddo_pkg::ST_TH_LO:
            begin
                mul_a      = {11'b0, m_reg[21:0]};
                mul_b      = {1'b0, cfg.inv_track};
                state_next = ddo_pkg::ST_DTH;
            end
            ddo_pkg::ST_DTH:   state_next = ddo_pkg::ST_HEAD;
            ddo_pkg::ST_HEAD:  state_next = ddo_pkg::ST_C_START;
            ddo_pkg::ST_C_START:
            begin
                cordic_start = 1'b1;
                state_next   = ddo_pkg::ST_C_WAIT;
            end
            ddo_pkg::ST_C_WAIT:
            begin
                if (cordic_sts.done)
                begin
                    state_next = ddo_pkg::ST_X_HI;
                end
            end
            ddo_pkg::ST_X_HI:
            begin
                mul_a      = {7'b0, cmag_reg[55:30]};
                mul_b      = {1'b0, cosmag_reg};
                state_next = ddo_pkg::ST_X_LO;
            end
            ddo_pkg::ST_X_LO:
            begin
                mul_a      = {3'b0, cmag_reg[29:0]};
                mul_b      = {1'b0, cosmag_reg};
                state_next = ddo_pkg::ST_X_RES;
            end
            ddo_pkg::ST_X_RES: state_next = ddo_pkg::ST_X_ADD;
            ddo_pkg::ST_X_ADD: state_next = ddo_pkg::ST_Y_HI;
            ddo_pkg::ST_Y_HI:
            begin
                mul_a      = {7'b0, cmag_reg[55:30]};
                mul_b      = {1'b0, sinmag_reg};
                state_next = ddo_pkg::ST_Y_LO;
            end
            ddo_pkg::ST_Y_LO:
            begin
                mul_a      = {3'b0, cmag_reg[29:0]};
                mul_b      = {1'b0, sinmag_reg};
                state_next = ddo_pkg::ST_Y_RES;
            end
            ddo_pkg::ST_Y_RES: state_next = ddo_pkg::ST_Y_ADD;
            ddo_pkg::ST_Y_ADD: state_next = ddo_pkg::ST_DONE;
            ddo_pkg::ST_DONE:
            begin
                // wait for the output register to free up
                if (!pose_valid_reg || !pose_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ddo_pkg::ST_IDLE;
                end
            end
            default:   state_next = ddo_pkg::ST_IDLE;
        endcase
        pose_valid_next = load_out || (pose_valid_reg && pose_stall);
    end

    // ---------------- datapath helpers ----------------
    always_comb
    begin
        sum_w = {tl_reg[55], tl_reg} + {tr_reg[55], tr_reg};

        // dtheta = min(|diff| * inv_track >> 24, max); |diff| split in two
        // 22-bit halves, exact sum only needed when no half overflows
        big_w    = (|m_reg[56:44]) && (cfg.inv_track != '0);
        sat_w    = big_w || (|hi_reg[53:21]) || (|prod[53:44]);
        th_sum_w = {2'b00, hi_reg[20:0], 22'b0} + {1'b0, prod[43:0]};
        q_w      = th_sum_w[44:24];
        qc_w     = (sat_w || (q_w > {2'b00, ddo_pkg::DTHETA_MAX})) ?
                   ddo_pkg::DTHETA_MAX : q_w[18:0];

        h_w = {heading_reg[19], heading_reg} + {dth_reg[19], dth_reg};
        if (h_w >= ddo_pkg::TWO_PI_Q16)
        begin
            h_wrap_w = h_w - ddo_pkg::TWO_PI_Q16;
        end
        else if (h_w <= -ddo_pkg::TWO_PI_Q16)
        begin
            h_wrap_w = h_w + ddo_pkg::TWO_PI_Q16;
        end
        else
        begin
            h_wrap_w = h_w;
        end

        cos_abs_w = cordic_sts.cos_v[CW-1] ? -cordic_sts.cos_v : cordic_sts.cos_v;
        sin_abs_w = cordic_sts.sin_v[CW-1] ? -cordic_sts.sin_v : cordic_sts.sin_v;
    end

    // ---------------- pose state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_left_reg  <= '0;
            last_right_reg <= '0;
            pose_x_reg     <= '0;
            pose_y_reg     <= '0;
            heading_reg    <= '0;
        end
        else
        begin
            if ((state_reg == ddo_pkg::ST_IDLE) && cnt_valid)
            begin
                last_left_reg  <= cnt_item.left_count;
                last_right_reg <= cnt_item.right_count;
            end
            if (state_reg == ddo_pkg::ST_HEAD)
            begin
                heading_reg <= h_wrap_w[19:0];
            end
            if (state_reg == ddo_pkg::ST_X_ADD)
            begin
                pose_x_reg <= sat_acc(pose_x_reg, r_reg, cneg_reg ^ cosneg_reg);
            end
            if (state_reg == ddo_pkg::ST_Y_ADD)
            begin
                pose_y_reg <= sat_acc(pose_y_reg, r_reg, cneg_reg ^ sinneg_reg);
            end
        end
    end

    // ---------------- working registers ----------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg) inside
            ddo_pkg::ST_IDLE:
            begin
                if (cnt_valid)
                begin
                    // count deltas wrap modulo 2^32
                    dl_reg <= cnt_item.left_count - last_left_reg;
                    dr_reg <= cnt_item.right_count - last_right_reg;
                end
            end
            ddo_pkg::ST_MUL_R: tl_reg <= prod[63:8];
            ddo_pkg::ST_DIFF:  tr_reg <= prod[63:8];
            ddo_pkg::ST_SUM:
            begin
                center_reg <= sum_w[56:1];
                diff_reg   <= {tr_reg[55], tr_reg} - {tl_reg[55], tl_reg};
            end
            ddo_pkg::ST_ABS:
            begin
                cneg_reg <= center_reg[55];
                cmag_reg <= center_reg[55] ? -center_reg : center_reg;
                dneg_reg <= diff_reg[56];
                m_reg    <= diff_reg[56] ? -diff_reg : diff_reg;
            end
            ddo_pkg::ST_TH_LO: hi_reg <= prod[53:0];
            ddo_pkg::ST_DTH:
            begin
                dth_reg <= dneg_reg ? -$signed({1'b0, qc_w}) : $signed({1'b0, qc_w});
            end
            ddo_pkg::ST_C_WAIT:
            begin
                if (cordic_sts.done)
                begin
                    cosneg_reg <= cordic_sts.cos_v[CW-1];
                    sinneg_reg <= cordic_sts.sin_v[CW-1];
                    cosmag_reg <= cos_abs_w[31:0];
                    sinmag_reg <= sin_abs_w[31:0];
                end
            end
            ddo_pkg::ST_X_LO, ddo_pkg::ST_Y_LO:
            begin
                acc_reg <= prod[57:0];
            end
            ddo_pkg::ST_X_RES, ddo_pkg::ST_Y_RES:
            begin
                // hi*c + (lo*c >> 30) = floor(|travel| * |c| / 2^30)
                r_reg <= {1'b0, acc_reg} + {27'b0, prod[61:30]};
            end
            ddo_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    pose_item_reg.pos_x       <= pose_x_reg;
                    pose_item_reg.pos_y       <= pose_y_reg;
                    pose_item_reg.heading_rad <= heading_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign cnt_stall  = (state_reg != ddo_pkg::ST_IDLE);
    assign pose_valid = pose_valid_reg;
    assign pose_item  = pose_item_reg;

endmodule

// ===== src/differential_drive_odometry_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// differential_drive_odometry_top - dead-reckoning pose from wheel counts
// Turns absolute left/right tachometer counts into an x, y, heading pose
// using a shared multiplier and an iterative CORDIC under one sequencer.
// ============================================================================
//
//  Channel  | Direction | Handshake                    | Payload
//  ---------+-----------+------------------------------+----------------------
//  cnt      | in        | cnt_valid / cnt_stall        | cnt_item (left, right)
//  pose     | out       | pose_valid / pose_stall      | pose_item (x, y, hdg)
//  config   | in/out    | psel penable pwrite pready   | paddr, pwdata, prdata
//
//  An item runs through the sequencer states from acceptance to a valid pose,
//  mostly CORDIC rotations plus eight shared multiplier passes; the next is
//  taken once the sequencer has returned to idle.
//  rst_n asynchronously clears the pose and previous counts, config to defaults.
//  cnt_stall is high while an item is in flight; a finished pose waits in an
//  output register on pose_stall while the next item is taken.
//
//  Processing order of one item:
//    1. count deltas (mod 2^32) times distance per count -> wheel travel
//    2. mean travel forward, difference times inv track -> heading change,
//       saturated and wrapped into the open range +-2*pi
//    3. CORDIC on the new heading gives cos and sin in Q30
//    4. x and y take travel * cos / sin with saturating adds
//
module differential_drive_odometry_top #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,

    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ddo_pkg::ADDR_W-1:0]  paddr,
    input  logic [ddo_pkg::DATA_W-1:0]  pwdata,
    output logic [ddo_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,

    // wheel count items
    input  logic                        cnt_valid,
    output logic                        cnt_stall,
    input  ddo_pkg::cnt_item_t          cnt_item,

    // pose items
    output logic                        pose_valid,
    input  logic                        pose_stall,
    output ddo_pkg::pose_item_t         pose_item
);

    ddo_pkg::cfg_t cfg;

    // register file: distance per count for each wheel, inverse track
    ddo_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer, multiplier, CORDIC and pose state
    ddo_core #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cnt_valid  (cnt_valid),
        .cnt_stall  (cnt_stall),
        .cnt_item   (cnt_item),
        .pose_valid (pose_valid),
        .pose_stall (pose_stall),
        .pose_item  (pose_item)
    );

`ifndef ASSERT_OFF
    // an accepted item keeps the input stalled on the next cycle
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cnt_valid && !cnt_stall) |=> cnt_stall
    ) else $error("input not stalled after accepting an item");

    // a new pose only appears at the end of work on an item
    a_pose_from_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(pose_valid) |-> $past(cnt_stall)
    ) else $error("pose item appeared without an item in flight");

    // heading stays inside the open range +-2*pi
    a_heading_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        pose_valid |-> (($signed(pose_item.heading_rad) < 20'sd411775) &&
                        ($signed(pose_item.heading_rad) > -20'sd411775))
    ) else $error("heading out of range");
`endif

endmodule
